@@ rtl/core/jib_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jet image binner package
// Shared types and fixed constants for the jet image binner core.
// ----------------------------------------------------------------------------
package jib_pkg;

	// Item kinds on the command port.
	localparam logic [1:0] KIND_AXIS    = 2'd0;
	localparam logic [1:0] KIND_DEPOSIT = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_WINDOW = 2'd1;
	localparam logic [1:0] ST_NO_PT  = 2'd2;

	// Field widths.
	localparam int PT_W  = 20;
	localparam int ETA_W = 16;
	localparam int PHI_W = 15;
	localparam int IDX_W = 8;

	// Angle offsets, signed Q.12 radians, wide enough for any eta difference.
	localparam int OFF_W = 18;
	localparam logic signed [OFF_W-1:0] PI_Q12     = 18'sd12868;
	localparam logic signed [OFF_W-1:0] TWO_PI_Q12 = 18'sd25736;
	localparam logic signed [OFF_W-1:0] ONE_Q12    = 18'sd4096;

	// Binning: (d + 1) * size >> 13, with d + 1 in 0..8192.
	localparam int MULT_A_W  = 14;
	localparam int BIN_SHIFT = 13;

	// Fraction divider: (pt << 16) / axis_pt, two quotient bits per cycle.
	localparam int FRAC_BITS  = 16;
	localparam int DIVIDEND_W = PT_W + FRAC_BITS;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STEPS  = DIVIDEND_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	// Pixel store port controls.
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage

@@ rtl/core/jib_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jet image binner fraction divider
// Iterative restoring divider that forms (pt << 16) / axis_pt, two bits a cycle.
// ----------------------------------------------------------------------------
module jib_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [jib_pkg::PT_W-1:0]             numer,
	input  logic [jib_pkg::PT_W-1:0]             denom,
	output logic                                 busy,
	output logic [jib_pkg::DIVIDEND_W-1:0]       quotient
);

	logic [jib_pkg::PT_W:0]           rem_q;
	logic [jib_pkg::DIVIDEND_W-1:0]   quo_q;
	logic [jib_pkg::PT_W-1:0]         denom_q;
	logic [jib_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic                             busy_q;

	logic [jib_pkg::PT_W:0]           rem_nx;
	logic [jib_pkg::DIVIDEND_W-1:0]   quo_nx;

	// The partial remainder stays below the divisor, so its top bit is free
	// before each shift.
	always_comb begin
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int i = 0; i < jib_pkg::DIV_BITS; i++) begin
			rem_nx = {rem_nx[jib_pkg::PT_W-1:0], quo_nx[jib_pkg::DIVIDEND_W-1]};
			quo_nx = {quo_nx[jib_pkg::DIVIDEND_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, denom_q}) begin
				rem_nx    = rem_nx - {1'b0, denom_q};
				quo_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= jib_pkg::DIV_CNT_W'(jib_pkg::DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			quo_q   <= {numer, {jib_pkg::FRAC_BITS{1'b0}}};
			denom_q <= denom;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ rtl/core/jib_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jet image binner pixel store
// Single-port-write, registered-read pixel memory with a clearing sweep.
// ----------------------------------------------------------------------------
module jib_mem #(
	parameter int DEPTH  = 50176,
	parameter int ADDR_W = 16,
	parameter int DATA_W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  jib_pkg::mem_ctl_t   ctl,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [DATA_W-1:0]   wdata,
	output logic [DATA_W-1:0]   rdata,
	output logic                clearing
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clearing_q;
	logic [DATA_W-1:0] rdata_q;

	// After reset every pixel is written to zero, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.wr) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

@@ rtl/core/jet_image_binner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jet image binner
// Bins jet constituents into a square image of pt fractions around the axis.
// ----------------------------------------------------------------------------
// A deposit computes offsets, checks the window, bins, forms the address, waits
// for the divider, which forms two quotient bits per cycle, then does a read
// and a write back; a read does address multiply, memory read, write back.
// Set-axis, unused, no-pt and out-of-image read items finish from idle.
// One item at a time: busy is high meanwhile. After reset the pixel store is
// swept to zero with busy high. Each result is shown for one cycle on done.
module jet_image_binner #(
	parameter int IMAGE_SIZE = 224,
	parameter int SUM_WIDTH  = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        kind,
	input  logic [jib_pkg::PT_W-1:0]          pt,
	input  logic signed [jib_pkg::ETA_W-1:0]  eta,
	input  logic signed [jib_pkg::PHI_W-1:0]  phi,
	input  logic [jib_pkg::IDX_W-1:0]         row,
	input  logic [jib_pkg::IDX_W-1:0]         col,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [SUM_WIDTH-1:0]              pixel_sum
);

	localparam int DEPTH   = IMAGE_SIZE * IMAGE_SIZE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int BIN_W   = $clog2(IMAGE_SIZE);
	localparam int IS_W    = $clog2(IMAGE_SIZE + 1);
	localparam int PROD_W  = jib_pkg::MULT_A_W + IS_W;
	localparam int BRAW_W  = PROD_W - jib_pkg::BIN_SHIFT;
	localparam int RNG_W   = 10;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_OFFS = 4'd1;
	localparam logic [3:0] S_WIN  = 4'd2;
	localparam logic [3:0] S_BINR = 4'd3;
	localparam logic [3:0] S_BINC = 4'd4;
	localparam logic [3:0] S_ADDR = 4'd5;
	localparam logic [3:0] S_DIVW = 4'd6;
	localparam logic [3:0] S_RD   = 4'd7;
	localparam logic [3:0] S_WR   = 4'd8;

	logic [3:0]                                state_q;
	logic                                      is_read_q;

	logic [jib_pkg::PT_W-1:0]                  axis_pt_q;
	logic signed [jib_pkg::ETA_W-1:0]          axis_eta_q;
	logic signed [jib_pkg::PHI_W-1:0]          axis_phi_q;

	logic [jib_pkg::PT_W-1:0]                  pt_q;
	logic signed [jib_pkg::ETA_W-1:0]          eta_q;
	logic signed [jib_pkg::PHI_W-1:0]          phi_q;
	logic signed [jib_pkg::OFF_W-1:0]          deta_q;
	logic signed [jib_pkg::OFF_W-1:0]          dphi_q;
	logic [BIN_W-1:0]                          r_q;
	logic [BIN_W-1:0]                          c_q;
	logic [ADDR_W-1:0]                         addr_q;

	logic                                      done_q;
	logic [1:0]                                status_q;
	logic [SUM_WIDTH-1:0]                      pixel_sum_q;

	logic                                      accept;
	logic                                      read_bad;
	logic                                      win_bad;
	logic signed [jib_pkg::OFF_W-1:0]          deta_nx;
	logic signed [jib_pkg::OFF_W-1:0]          dphi_raw;
	logic signed [jib_pkg::OFF_W-1:0]          dphi_hi;
	logic signed [jib_pkg::OFF_W-1:0]          dphi_nx;
	logic signed [jib_pkg::OFF_W-1:0]          off_sel;
	logic signed [jib_pkg::OFF_W-1:0]          off_plus;
	logic [jib_pkg::MULT_A_W-1:0]              mult_a;
	logic [PROD_W-1:0]                         prod;
	logic [BRAW_W-1:0]                         bin_raw;
	logic [BIN_W-1:0]                          bin_val;

	logic                                      div_start;
	logic                                      div_busy;
	logic [jib_pkg::DIVIDEND_W-1:0]            quotient;
	logic [SUM_WIDTH-1:0]                      frac_sat;
	logic [SUM_WIDTH:0]                        acc;
	logic [SUM_WIDTH-1:0]                      acc_sat;

	jib_pkg::mem_ctl_t                         mem_ctl;
	logic [SUM_WIDTH-1:0]                      mem_wdata;
	logic [SUM_WIDTH-1:0]                      mem_rdata;
	logic                                      mem_clearing;

	assign busy   = (state_q != S_IDLE) || mem_clearing;
	assign accept = start && !busy;

	assign read_bad = (RNG_W'(row) >= RNG_W'(IMAGE_SIZE)) || (RNG_W'(col) >= RNG_W'(IMAGE_SIZE));

	// Offsets from the axis; phi is wrapped once into [-pi, pi].
	assign deta_nx  = jib_pkg::OFF_W'(eta_q) - jib_pkg::OFF_W'(axis_eta_q);
	assign dphi_raw = jib_pkg::OFF_W'(phi_q) - jib_pkg::OFF_W'(axis_phi_q);
	assign dphi_hi  = (dphi_raw > jib_pkg::PI_Q12) ? dphi_raw - jib_pkg::TWO_PI_Q12 : dphi_raw;
	assign dphi_nx  = (dphi_hi < -jib_pkg::PI_Q12) ? dphi_hi + jib_pkg::TWO_PI_Q12 : dphi_hi;

	assign win_bad = (deta_q > jib_pkg::ONE_Q12) || (deta_q < -jib_pkg::ONE_Q12) ||
		(dphi_q > jib_pkg::ONE_Q12) || (dphi_q < -jib_pkg::ONE_Q12);

	// One small multiplier serves both bins and the pixel address.
	assign off_sel  = (state_q == S_BINR) ? deta_q : dphi_q;
	assign off_plus = off_sel + jib_pkg::ONE_Q12;
	assign mult_a   = (state_q == S_ADDR) ? jib_pkg::MULT_A_W'(r_q) :
		jib_pkg::MULT_A_W'(off_plus);
	assign prod     = PROD_W'(mult_a) * PROD_W'(IMAGE_SIZE);
	assign bin_raw  = prod[PROD_W-1:jib_pkg::BIN_SHIFT];
	assign bin_val  = (bin_raw > BRAW_W'(IMAGE_SIZE - 1)) ? BIN_W'(IMAGE_SIZE - 1) :
		BIN_W'(bin_raw);

	// Saturating pixel update.
	assign frac_sat = (|quotient[jib_pkg::DIVIDEND_W-1:SUM_WIDTH]) ? '1 :
		quotient[SUM_WIDTH-1:0];
	assign acc      = {1'b0, mem_rdata} + {1'b0, frac_sat};
	assign acc_sat  = acc[SUM_WIDTH] ? '1 : acc[SUM_WIDTH-1:0];

	assign div_start   = (state_q == S_WIN) && !win_bad;
	assign mem_ctl.rd  = (state_q == S_RD);
	assign mem_ctl.wr  = (state_q == S_WR);
	assign mem_wdata   = is_read_q ? '0 : acc_sat;

	jib_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (pt_q),
		.denom    (axis_pt_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	jib_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (SUM_WIDTH)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.addr     (addr_q),
		.wdata    (mem_wdata),
		.rdata    (mem_rdata),
		.clearing (mem_clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			status_q    <= jib_pkg::ST_OK;
			pixel_sum_q <= '0;
			is_read_q   <= 1'b0;
			axis_pt_q   <= '0;
			axis_eta_q  <= '0;
			axis_phi_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q    <= jib_pkg::ST_OK;
						pixel_sum_q <= '0;
						is_read_q   <= (kind == jib_pkg::KIND_READ);
						case (kind)
							jib_pkg::KIND_AXIS: begin
								axis_pt_q  <= pt;
								axis_eta_q <= eta;
								axis_phi_q <= phi;
								done_q     <= 1'b1;
							end
							jib_pkg::KIND_DEPOSIT: begin
								if (axis_pt_q == '0) begin
									status_q <= jib_pkg::ST_NO_PT;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_OFFS;
								end
							end
							jib_pkg::KIND_READ: begin
								if (read_bad) begin
									status_q <= jib_pkg::ST_WINDOW;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_ADDR;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_OFFS: state_q <= S_WIN;
				S_WIN: begin
					if (win_bad) begin
						status_q <= jib_pkg::ST_WINDOW;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_BINR;
					end
				end
				S_BINR: state_q <= S_BINC;
				S_BINC: state_q <= S_ADDR;
				S_ADDR: state_q <= is_read_q ? S_RD : S_DIVW;
				S_DIVW: begin
					if (!div_busy) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					if (is_read_q) begin
						pixel_sum_q <= mem_rdata;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_q  <= pt;
			eta_q <= eta;
			phi_q <= phi;
			r_q   <= BIN_W'(row);
			c_q   <= BIN_W'(col);
		end else begin
			if (state_q == S_BINR) begin
				r_q <= bin_val;
			end
			if (state_q == S_BINC) begin
				c_q <= bin_val;
			end
		end
		if (state_q == S_OFFS) begin
			deta_q <= deta_nx;
			dphi_q <= dphi_nx;
		end
		if (state_q == S_ADDR) begin
			addr_q <= ADDR_W'(prod + PROD_W'(c_q));
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign pixel_sum = pixel_sum_q;

	// The store sweep after reset always holds the command port off.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_clearing |-> busy)
		else $error("pixel store clearing while the block reports idle");

	// The divider only runs while a deposit is being processed.
	a_div_in_deposit: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_BINR || state_q == S_BINC ||
			state_q == S_ADDR || state_q == S_DIVW))
		else $error("divider running outside a deposit");

	// A sequence only starts from an accepted command.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != S_IDLE) && ($past(state_q) == S_IDLE)) |-> $past(accept))
		else $error("left idle without an accepted command");

	// Only a successful read returns a nonzero pixel value.
	a_sum_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pixel_sum != '0) |-> (status == jib_pkg::ST_OK))
		else $error("pixel value returned with an error status");

	// A pixel write happens only at the end of a sequence, with a result next.
	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr |=> done)
		else $error("pixel written without a result beat");

endmodule

@@ sim/tb_jet_image_binner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jet image binner testbench
// Drives set-axis, deposit, read and unused commands through the start/busy
// port. A scoreboard predicts each result from its own copy of the jet axis
// and the pixel image, and compares it field by field with every beat that
// comes out on done. The directed part hits the window edges, the phi wrap,
// saturation and the zero jet pt case. The random part builds many jets from
// clustered deposits and reads the touched pixels back.
// ----------------------------------------------------------------------------
module tb_jet_image_binner;

	localparam int IMG_N       = 224;
	localparam int SUM_W       = 24;
	localparam int PI_Q        = jib_pkg::PI_Q12;
	localparam int TWO_PI_Q    = jib_pkg::TWO_PI_Q12;
	localparam int ONE_Q       = jib_pkg::ONE_Q12;
	localparam int ITEM_TARGET = 1250;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class image_scoreboard;
		typedef struct {
			logic [1:0]       status;
			logic [SUM_W-1:0] sum;
		} pixel_result_t;

		bit [jib_pkg::PT_W-1:0]         jet_pt;
		bit signed [jib_pkg::ETA_W-1:0] jet_eta;
		bit signed [jib_pkg::PHI_W-1:0] jet_phi;
		bit [SUM_W-1:0]                 image_pixels [IMG_N*IMG_N];
		pixel_result_t                  pending_results [$];
		int                             hot_pixels [$];
		int errors, n_binned, n_window, n_no_pt, n_reads, n_hits, n_saturated;

		task report(string msg);
			errors++;
			$display("MISMATCH at %0t ns: %s", $time, msg);
		endtask

		function int bin_of(int d);
			int b;
			b = ((d + ONE_Q) * IMG_N) >>> jib_pkg::BIN_SHIFT;
			if (b > IMG_N - 1)
				b = IMG_N - 1;
			return b;
		endfunction

		// Works out the result of one accepted command and updates the image.
		function void predict_item(logic [1:0] k, logic [jib_pkg::PT_W-1:0] p,
				logic signed [jib_pkg::ETA_W-1:0] e, logic signed [jib_pkg::PHI_W-1:0] ph,
				logic [jib_pkg::IDX_W-1:0] r, logic [jib_pkg::IDX_W-1:0] c);
			pixel_result_t res;
			int deta, dphi, idx;
			longint frac, acc;
			res.status = jib_pkg::ST_OK;
			res.sum = '0;
			case (k)
				jib_pkg::KIND_AXIS: begin
					jet_pt = p;
					jet_eta = e;
					jet_phi = ph;
				end
				jib_pkg::KIND_DEPOSIT: begin
					if (jet_pt == 0) begin
						res.status = jib_pkg::ST_NO_PT;
						n_no_pt++;
					end else begin
						deta = int'(e) - int'(jet_eta);
						dphi = int'(ph) - int'(jet_phi);
						if (dphi > PI_Q)
							dphi -= TWO_PI_Q;
						if (dphi < -PI_Q)
							dphi += TWO_PI_Q;
						if (deta > ONE_Q || deta < -ONE_Q || dphi > ONE_Q || dphi < -ONE_Q) begin
							res.status = jib_pkg::ST_WINDOW;
							n_window++;
						end else begin
							idx = bin_of(deta) * IMG_N + bin_of(dphi);
							frac = (longint'(p) << jib_pkg::FRAC_BITS) / longint'(jet_pt);
							acc = longint'(image_pixels[idx]) + frac;
							if (acc > (longint'(1) << SUM_W) - 1)
								acc = (longint'(1) << SUM_W) - 1;
							image_pixels[idx] = acc[SUM_W-1:0];
							hot_pixels.push_back(idx);
							n_binned++;
						end
					end
				end
				jib_pkg::KIND_READ: begin
					if (r >= IMG_N || c >= IMG_N) begin
						res.status = jib_pkg::ST_WINDOW;
					end else begin
						idx = int'(r) * IMG_N + int'(c);
						res.sum = image_pixels[idx];
						image_pixels[idx] = '0;
						n_reads++;
						if (res.sum != 0)
							n_hits++;
						if (&res.sum)
							n_saturated++;
					end
				end
				default: ;
			endcase
			pending_results.push_back(res);
		endfunction

		task check_result(logic [1:0] st, logic [SUM_W-1:0] sum);
			pixel_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result with none pending: status=%0d sum=%h", st, sum));
			end else begin
				want = pending_results.pop_front();
				if (st !== want.status)
					report($sformatf("status %0d, wanted %0d", st, want.status));
				if (sum !== want.sum)
					report($sformatf("pixel_sum %h, wanted %h", sum, want.sum));
			end
		endtask
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	logic [1:0]                       kind;
	logic [jib_pkg::PT_W-1:0]         pt;
	logic signed [jib_pkg::ETA_W-1:0] eta;
	logic signed [jib_pkg::PHI_W-1:0] phi;
	logic [jib_pkg::IDX_W-1:0]        row;
	logic [jib_pkg::IDX_W-1:0]        col;
	logic                             done;
	logic [1:0]                       status;
	logic [SUM_W-1:0]                 pixel_sum;

	image_scoreboard sb = new();
	int items_sent;
	int cur_pt, cur_eta, cur_phi;

	jet_image_binner #(
		.IMAGE_SIZE(IMG_N),
		.SUM_WIDTH (SUM_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.pt       (pt),
		.eta      (eta),
		.phi      (phi),
		.row      (row),
		.col      (col),
		.done     (done),
		.status   (status),
		.pixel_sum(pixel_sum)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, pixel_sum);
	end

	function automatic int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Offset from the jet axis: window edges, a per-jet cluster, or a spread.
	function automatic int pick_offset(int center);
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return -ONE_Q - 1;
					1: return -ONE_Q;
					2: return ONE_Q;
					default: return ONE_Q + 1;
				endcase
			end
			1, 2, 3: return center + int'($urandom_range(0, 80)) - 40;
			default: return int'($urandom_range(0, 8600)) - 4300;
		endcase
	endfunction

	function automatic int pick_pt();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, (1 << jib_pkg::PT_W) - 1);
			1: return 0;
			default: return $urandom_range(0, cur_pt);
		endcase
	endfunction

	task automatic send_item(input int k, input int p, input int e, input int ph,
			input int r, input int c);
		logic [1:0]                       k_v;
		logic [jib_pkg::PT_W-1:0]         p_v;
		logic signed [jib_pkg::ETA_W-1:0] e_v;
		logic signed [jib_pkg::PHI_W-1:0] ph_v;
		logic [jib_pkg::IDX_W-1:0]        r_v;
		logic [jib_pkg::IDX_W-1:0]        c_v;
		bit calm;
		k_v  = k[1:0];
		p_v  = p[jib_pkg::PT_W-1:0];
		e_v  = e[jib_pkg::ETA_W-1:0];
		ph_v = ph[jib_pkg::PHI_W-1:0];
		r_v  = r[jib_pkg::IDX_W-1:0];
		c_v  = c[jib_pkg::IDX_W-1:0];
		// A stretch in the middle of the run goes without any gaps.
		calm = items_sent >= 500 && items_sent < 750;
		while (!calm && $urandom_range(0, 99) < 28) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		kind  <= k_v;
		pt    <= p_v;
		eta   <= e_v;
		phi   <= ph_v;
		row   <= r_v;
		col   <= c_v;
		do @(posedge clk); while (busy);
		sb.predict_item(k_v, p_v, e_v, ph_v, r_v, c_v);
		items_sent++;
	endtask

	task automatic send_axis(input int p, input int e, input int ph);
		cur_pt = p;
		cur_eta = e;
		cur_phi = ph;
		send_item(jib_pkg::KIND_AXIS, p, e, ph, $urandom, $urandom);
	endtask

	task automatic send_deposit(input int p, input int de, input int dp);
		int e, ph;
		e = clamp(cur_eta + de, -32768, 32767);
		ph = cur_phi + dp;
		if ($urandom_range(0, 3) == 0)
			ph += (ph >= 0) ? -TWO_PI_Q : TWO_PI_Q;
		if (ph > 16383)
			ph -= TWO_PI_Q;
		else if (ph < -16384)
			ph += TWO_PI_Q;
		ph = clamp(ph, -16384, 16383);
		send_item(jib_pkg::KIND_DEPOSIT, p, e, ph, $urandom, $urandom);
	endtask

	task automatic send_read(input int r, input int c);
		send_item(jib_pkg::KIND_READ, $urandom, $urandom, $urandom, r, c);
	endtask

	task automatic read_hot_pixel();
		int n, idx;
		n = sb.hot_pixels.size();
		if (n == 0) begin
			send_read($urandom_range(0, IMG_N - 1), $urandom_range(0, IMG_N - 1));
		end else begin
			idx = sb.hot_pixels[n - 1 - $urandom_range(0, (n > 40) ? 39 : n - 1)];
			send_read(idx / IMG_N, idx % IMG_N);
		end
	endtask

	// Full-range fields of any kind except a new axis.
	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: send_item(jib_pkg::KIND_DEPOSIT, $urandom, $urandom, $urandom, $urandom,
				$urandom);
			1: send_read($urandom_range(0, 255), $urandom_range(0, 255));
			default: send_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
		endcase
	endtask

	initial begin
		int n_dep, n_rd, c_eta, c_phi, waited;
		arst_n = 1'b0;
		start  = 1'b0;
		kind   = jib_pkg::KIND_AXIS;
		pt     = '0;
		eta    = '0;
		phi    = '0;
		row    = '0;
		col    = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed commands.
		send_item(jib_pkg::KIND_DEPOSIT, 20'hFFFFF, 0, 0, 0, 0);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, 0, 0);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, IMG_N - 1, IMG_N - 1);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, IMG_N, 0);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, 0, 255);
		send_item(KIND_UNUSED, 20'hFFFFF, -1, -1, 255, 255);
		send_item(jib_pkg::KIND_AXIS, 6400, 0, 0, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 6400, -4096, -4096, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 3200, 4096, 4096, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 100, 4097, 0, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 100, 0, -4097, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 0, 0, 0, 0, 0);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, 0, 0);
		// Unit jet pt drives the pixel into saturation; phi wraps upward.
		send_item(jib_pkg::KIND_AXIS, 1, -32768, 12000, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 20'hFFFFF, 32767, 12000, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 20'hFFFFF, -32768, -14000, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 1, -32668, -14000, 0, 0);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, 112, 104);
		// Phi wraps downward; a new axis leaves the image alone.
		send_item(jib_pkg::KIND_AXIS, 20'hFFFFF, -100, -12000, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 20'hFFFFF, 0, 14000, 0, 0);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, IMG_N - 1, IMG_N - 1);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, 114, 119);
		send_item(jib_pkg::KIND_AXIS, 0, 5, 5, 0, 0);
		send_item(jib_pkg::KIND_DEPOSIT, 500, 5, 5, 0, 0);
		send_item(jib_pkg::KIND_READ, 0, 0, 0, 128, 127);

		// Random jets: an axis, a burst of deposits, then readback.
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: cur_pt = 0;
				1: cur_pt = $urandom_range(1, 64);
				2: cur_pt = $urandom_range(0, (1 << jib_pkg::PT_W) - 1);
				default: cur_pt = $urandom_range(64, 200000);
			endcase
			if ($urandom_range(0, 3) == 0)
				cur_eta = int'($urandom_range(0, 65535)) - 32768;
			else
				cur_eta = int'($urandom_range(0, 40000)) - 20000;
			send_axis(cur_pt, cur_eta, int'($urandom_range(0, 32767)) - 16384);
			c_eta = int'($urandom_range(0, 7000)) - 3500;
			c_phi = int'($urandom_range(0, 7000)) - 3500;
			n_dep = $urandom_range(4, 24);
			repeat (n_dep) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_deposit(pick_pt(), pick_offset(c_eta), pick_offset(c_phi));
			end
			n_rd = $urandom_range(1, 6);
			repeat (n_rd) begin
				if ($urandom_range(0, 7) == 0)
					send_noise();
				else
					read_hot_pixel();
			end
		end
		@(negedge clk);
		start <= 1'b0;

		waited = 0;
		while (sb.pending_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending_results.size() != 0) begin
			$display("FAILED: results differ");
		end else begin
			repeat (40) @(posedge clk);
			if (sb.pending_results.size() != 0)
				sb.report($sformatf("%0d results never came", sb.pending_results.size()));
			$display("Ran %0d commands: %0d deposits binned, %0d outside the window, %0d with no jet pt.",
				items_sent, sb.n_binned, sb.n_window, sb.n_no_pt);
			$display("Read %0d pixels, %0d of them nonzero and %0d saturated; %0d mismatches.",
				sb.n_reads, sb.n_hits, sb.n_saturated, sb.errors);
			if (sb.errors == 0)
				$display("PASSED: all results match");
			else
				$display("FAILED: results differ");
		end
		$finish;
	end

	// Covers the clearing sweep after reset plus the slowest legal run several times over.
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/jib_pkg.sv
rtl/core/jib_div.sv
rtl/core/jib_mem.sv
rtl/core/jet_image_binner.sv
sim/tb_jet_image_binner.sv
